// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned SpqDepth         = 64;
  localparam int unsigned SpqTagWidth      = 32;
  localparam int unsigned SpqPriorityWidth = 32;

  localparam int unsigned KindWidth   = 2;
  localparam int unsigned StatusWidth = 2;

  localparam logic [KindWidth-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KindWidth-1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [KindWidth-1:0] KIND_CLEAR   = 2'd2;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

// ----- hdl/spq_if.sv -----
`timescale 1ns / 1ps

interface spq_req_if #(
  parameter int unsigned TAG_WIDTH      = spq_pkg::SpqTagWidth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::SpqPriorityWidth
);
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::KindWidth-1:0]    kind;
  logic signed [PRIORITY_WIDTH-1:0] priority_req;
  logic [TAG_WIDTH-1:0]             tag;

  modport source (output valid, kind, priority_req, tag, input ready);
  modport sink   (input valid, kind, priority_req, tag, output ready);
endinterface

interface spq_rsp_if #(
  parameter int unsigned TAG_WIDTH      = spq_pkg::SpqTagWidth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::SpqPriorityWidth,
  parameter int unsigned COUNT_WIDTH    = $clog2(spq_pkg::SpqDepth + 1)
);
  logic                             valid;
  logic                             ready;
  logic [TAG_WIDTH-1:0]             out_tag;
  logic signed [PRIORITY_WIDTH-1:0] out_priority;
  logic [COUNT_WIDTH-1:0]           count;
  logic [spq_pkg::StatusWidth-1:0]  status;

  modport source (output valid, out_tag, out_priority, count, status, input ready);
  modport sink   (input valid, out_tag, out_priority, count, status, output ready);
endinterface

// ----- hdl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned TAG_WIDTH      = SpqTagWidth,
  parameter int unsigned PRIORITY_WIDTH = SpqPriorityWidth
) (
  input  logic                      clk_i,
  input  spq_ctrl_t                 ctrl_i,
  input  logic                      occupied_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic [TAG_WIDTH-1:0]      new_tag_i,
  input  logic                      left_keep_i,
  input  logic [PRIORITY_WIDTH-1:0] left_prio_i,
  input  logic [TAG_WIDTH-1:0]      left_tag_i,
  input  logic [PRIORITY_WIDTH-1:0] right_prio_i,
  input  logic [TAG_WIDTH-1:0]      right_tag_i,
  output logic                      keep_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o,
  output logic [TAG_WIDTH-1:0]      tag_o
);

  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic [TAG_WIDTH-1:0]      tag_q, tag_d;

  // Stay put on enqueue only if the stored entry is strictly smaller.
  assign keep_o = occupied_i && ($signed(prio_q) < $signed(new_prio_i));

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.enq && !keep_o) begin
      if (left_keep_i) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end else begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end
    end else if (ctrl_i.deq) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

// ----- hdl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Modport  Beat
// req_i    in   sink     kind, priority_req, tag
// rsp_o    out  source   out_tag, out_priority, count, status
//
// One request per cycle while the result register is free or draining: every
// cell compares against the new priority at once and shifts in the same edge.
// The result beat appears in the cycle after the request beat is taken.
// Reset clears the count and the result valid; cell contents are not reset.
// A request is taken while the result register is empty or being drained.

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH          = SpqDepth,
  parameter int unsigned TAG_WIDTH      = SpqTagWidth,
  parameter int unsigned PRIORITY_WIDTH = SpqPriorityWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  logic [CountWidth-1:0] count_q, count_d;
  logic                  rsp_valid_q;
  logic [TAG_WIDTH-1:0]      rsp_tag_q, rsp_tag_d;
  logic [PRIORITY_WIDTH-1:0] rsp_prio_q, rsp_prio_d;
  logic [CountWidth-1:0]     rsp_count_q;
  logic [StatusWidth-1:0]    rsp_status_q, rsp_status_d;

  logic      accept;
  logic      is_full;
  logic      is_empty;
  spq_ctrl_t ctrl;

  logic                      cell_keep [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];
  logic [TAG_WIDTH-1:0]      cell_tag  [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = (count_q == CountWidth'(DEPTH));
  assign is_empty    = (count_q == '0);

  assign ctrl.enq = accept && (req_i.kind == KIND_ENQUEUE) && !is_full;
  assign ctrl.deq = accept && (req_i.kind == KIND_DEQUEUE) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_keep;
    logic [PRIORITY_WIDTH-1:0] left_prio, right_prio;
    logic [TAG_WIDTH-1:0]      left_tag, right_tag;

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_prio = '0;
      assign left_tag  = '0;
    end else begin : g_body
      assign left_keep = cell_keep[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_tag  = '0;
    end else begin : g_mid
      assign right_prio = cell_prio[i+1];
      assign right_tag  = cell_tag[i+1];
    end

    spq_cell #(
      .TAG_WIDTH     (TAG_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CountWidth'(i) < count_q),
      .new_prio_i  (req_i.priority_req),
      .new_tag_i   (req_i.tag),
      .left_keep_i (left_keep),
      .left_prio_i (left_prio),
      .left_tag_i  (left_tag),
      .right_prio_i(right_prio),
      .right_tag_i (right_tag),
      .keep_o      (cell_keep[i]),
      .prio_o      (cell_prio[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    rsp_status_d = STATUS_OK;
    rsp_tag_d    = is_empty ? '0 : cell_tag[0];
    rsp_prio_d   = is_empty ? '0 : cell_prio[0];
    case (req_i.kind)
      KIND_ENQUEUE: begin
        if (is_full) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CountWidth'(1);
          // New entry becomes head unless the old head is strictly smaller.
          if (!cell_keep[0]) begin
            rsp_tag_d  = req_i.tag;
            rsp_prio_d = req_i.priority_req;
          end
        end
      end
      KIND_DEQUEUE: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          count_d = count_q - CountWidth'(1);
        end
      end
      KIND_CLEAR: begin
        count_d    = '0;
        rsp_tag_d  = '0;
        rsp_prio_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_tag_q    <= rsp_tag_d;
      rsp_prio_q   <= rsp_prio_d;
      rsp_count_q  <= count_d;
      rsp_status_q <= rsp_status_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.out_tag      = rsp_tag_q;
  assign rsp_o.out_priority = rsp_prio_q;
  assign rsp_o.count        = rsp_count_q;
  assign rsp_o.status       = rsp_status_q;

endmodule

// ----- tb/sv/tb_sorted_priority_queue.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  logic [spq_pkg::SpqTagWidth-1:0]             tag;
  logic signed [spq_pkg::SpqPriorityWidth-1:0] prio;
  logic [$clog2(spq_pkg::SpqDepth + 1)-1:0]    count;
  logic [spq_pkg::StatusWidth-1:0]             status;
} spq_beat_t;

class queue_scoreboard;
  localparam int unsigned CountBits = $clog2(spq_pkg::SpqDepth + 1);

  logic signed [spq_pkg::SpqPriorityWidth-1:0] held_prio[$];
  logic [spq_pkg::SpqTagWidth-1:0]             held_tag[$];
  spq_beat_t                                   awaited[$];
  int unsigned                                 mismatches;

  function new();
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  function void note_request(input logic [spq_pkg::KindWidth-1:0] kind,
                             input logic signed [spq_pkg::SpqPriorityWidth-1:0] prio,
                             input logic [spq_pkg::SpqTagWidth-1:0] tag);
    spq_beat_t beat;
    int        slot;
    bit        removed;
    beat    = '0;
    removed = 1'b0;
    beat.status = spq_pkg::STATUS_OK;
    case (kind)
      spq_pkg::KIND_ENQUEUE: begin
        if (held_prio.size() >= spq_pkg::SpqDepth) begin
          beat.status = spq_pkg::STATUS_FULL;
        end else begin
          // land ahead of the first entry that is not smaller: newest wins ties
          slot = 0;
          while (slot < held_prio.size() && held_prio[slot] < prio) slot++;
          held_prio.insert(slot, prio);
          held_tag.insert(slot, tag);
        end
      end
      spq_pkg::KIND_DEQUEUE: begin
        if (held_prio.size() == 0) begin
          beat.status = spq_pkg::STATUS_EMPTY;
        end else begin
          beat.prio = held_prio.pop_front();
          beat.tag  = held_tag.pop_front();
          removed   = 1'b1;
        end
      end
      spq_pkg::KIND_CLEAR: begin
        held_prio.delete();
        held_tag.delete();
      end
      default: ;
    endcase
    if (!removed && held_prio.size() != 0) begin
      beat.tag  = held_tag[0];
      beat.prio = held_prio[0];
    end
    beat.count = CountBits'(held_prio.size());
    awaited.push_back(beat);
  endfunction

  function void check_result(input spq_beat_t got);
    spq_beat_t want;
    if (awaited.size() == 0) begin
      $error("result beat with no request outstanding");
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (got.tag !== want.tag) begin
      $error("out_tag: expected %h, got %h", want.tag, got.tag);
      mismatches++;
    end
    if (got.prio !== want.prio) begin
      $error("out_priority: expected %h, got %h", want.prio, got.prio);
      mismatches++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
  endfunction
endclass

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned CLK_PERIOD = 12;
  localparam logic [KindWidth-1:0] KIND_SPARE = 2'd3;
  localparam logic signed [SpqPriorityWidth-1:0] PRIO_MAX = 32'sh7fff_ffff;
  localparam logic signed [SpqPriorityWidth-1:0] PRIO_MIN = 32'sh8000_0000;
  localparam logic signed [SpqPriorityWidth-1:0] PRIO_ONE = 32'sh0001_0000;

  logic            clk = 1'b0;
  logic            rst_n;
  bit              quiet = 1'b0;
  queue_scoreboard ledger;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly back to back, sometimes a short hold, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SpqPriorityWidth-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom;
    // tight cluster around zero to force plenty of ties
    if (roll < 8) return int'($urandom_range(0, 7)) - 4;
    case ($urandom_range(0, 3))
      0:       return PRIO_MIN;
      1:       return PRIO_MAX;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  task automatic send_request(input logic [KindWidth-1:0] kind,
                              input logic signed [SpqPriorityWidth-1:0] prio,
                              input logic [SpqTagWidth-1:0] tag);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.priority_req <= prio;
    req_if.tag          <= tag;
    do @(posedge clk); while (!req_if.ready);
    ledger.note_request(kind, prio, tag);
  endtask

  task automatic run_mix(input int unsigned items, input int unsigned enq_pct,
                         input int unsigned clr_per_mille);
    int unsigned          roll;
    logic [KindWidth-1:0] kind;
    repeat (items) begin
      roll = $urandom_range(0, 999);
      if (roll < 10) kind = KIND_SPARE;
      else if (roll < 10 + clr_per_mille) kind = KIND_CLEAR;
      else if ($urandom_range(0, 99) < enq_pct) kind = KIND_ENQUEUE;
      else kind = KIND_DEQUEUE;
      send_request(kind, pick_priority(), $urandom);
    end
  endtask

  task automatic fill_to_capacity();
    repeat (SpqDepth + 1) send_request(KIND_ENQUEUE, pick_priority(), $urandom);
  endtask

  // hold the request side until every result beat is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    ledger = new();
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.kind         <= KIND_ENQUEUE;
    req_if.priority_req <= '0;
    req_if.tag          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_DEQUEUE, PRIO_MAX, 32'hffff_ffff);
    send_request(KIND_SPARE, '0, '0);
    send_request(KIND_ENQUEUE, PRIO_MAX, 32'hffff_ffff);
    send_request(KIND_ENQUEUE, PRIO_MIN, 32'h0000_0000);
    send_request(KIND_ENQUEUE, '0, 32'ha5a5_a5a5);
    send_request(KIND_ENQUEUE, '0, 32'h5a5a_5a5a);
    send_request(KIND_ENQUEUE, -1, 32'h0000_0001);
    send_request(KIND_ENQUEUE, PRIO_ONE, 32'h8000_0000);
    send_request(KIND_SPARE, PRIO_MIN, 32'hffff_ffff);
    repeat (4) send_request(KIND_DEQUEUE, '0, '0);
    send_request(KIND_ENQUEUE, PRIO_MIN, 32'h1234_5678);
    send_request(KIND_CLEAR, PRIO_MAX, 32'hffff_ffff);
    send_request(KIND_DEQUEUE, '0, '0);
    send_request(KIND_ENQUEUE, PRIO_MAX, 32'h0000_0002);
    send_request(KIND_ENQUEUE, PRIO_MAX, 32'h0000_0003);
    repeat (3) send_request(KIND_DEQUEUE, '0, '0);
    send_request(KIND_SPARE, '0, '0);

    quiet = 1'b1;
    run_mix(140, 50, 5);
    quiet = 1'b0;
    run_mix(170, 80, 2);
    fill_to_capacity();
    drain_results();
    run_mix(190, 20, 2);
    run_mix(170, 55, 10);
    fill_to_capacity();
    send_request(KIND_CLEAR, pick_priority(), $urandom);
    run_mix(150, 65, 5);

    drain_results();
    repeat (4) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    spq_beat_t   got;
    int unsigned ready_hold;
    ready_hold = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        got.tag    = rsp_if.out_tag;
        got.prio   = rsp_if.out_priority;
        got.count  = rsp_if.count;
        got.status = rsp_if.status;
        ledger.check_result(got);
      end
      if (ready_hold != 0) begin
        rsp_if.ready <= 1'b0;
        ready_hold--;
      end else begin
        rsp_if.ready <= 1'b1;
        ready_hold = idle_span();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
